// ===== hdl/phr_pkg.sv =====
// phr_pkg: mode codes, rounding constants and types for the pcm halve and requantize unit
// no dependencies; imported by pcm_halve_and_requantize_unit, phr_checker and the testbench
package phr_pkg;

    typedef logic [1:0]  t_mode;
    typedef logic [15:0] t_sample;
    typedef logic [31:0] t_acc;

    localparam t_mode MODE_HALVE16   = 2'd0;
    localparam t_mode MODE_HALVE8    = 2'd1;
    localparam t_mode MODE_HALVE_RED = 2'd2;
    localparam t_mode MODE_REDUCE    = 2'd3;

    localparam t_acc PAIR_BIAS     = 32'h0002_0000;
    localparam t_acc H16_MASK      = 32'h0003_FFFC;
    localparam t_acc H8_MASK       = 32'h0000_03FC;
    localparam t_acc HR_MASK       = 32'hFFFF_FC00;
    localparam t_acc HR_LIMIT      = 32'h0003_FC00;
    localparam t_acc HR_ROUND      = 32'h0000_0200;
    localparam t_acc RED_ROUND     = 32'h0000_007F;
    localparam t_acc RED_MASK      = 32'hFFFF_FF00;
    localparam t_acc RED_LIMIT     = 32'h0000_FF00;
    localparam t_acc RED_BIAS      = 32'h0000_8000;
    localparam t_acc QUARTER_ROUND = 32'h0000_0002;
    localparam t_sample OUT_OFFSET = 16'h8000;

    function automatic t_acc sext16(input t_sample v);
        sext16 = {{16{v[15]}}, v};
    endfunction

    // v read as signed exceeds limit (limit is positive)
    function automatic logic signed_gt(input t_acc v, input t_acc limit);
        signed_gt = !v[31] && (v > limit);
    endfunction

endpackage

// ===== hdl/pcm_halve_and_requantize_unit.sv =====
// pcm_halve_and_requantize_unit: decimate-by-two with error feedback requantizer
// depends on phr_pkg
//
// Takes one PCM word per cycle, unless a result is held waiting on i_ready, and
// returns at most one word per input word. A word is registered at the input, then
// the pair sum, error-feedback accumulator update, rounding and clamp are done
// combinationally between the input register and the output register, so sustained
// rate is one word per clock. The loop through the 32-bit accumulator sets that rate.
// In the halving modes an even-phase word gives no result, and a pair's result is
// computed in the mode current at its odd word. The mode register may be written
// only while the unit is idle.
module pcm_halve_and_requantize_unit
    import phr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_sample_in,
    input  logic        i_first_of_buffer,
    // result word channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_sample_out,
    // mode register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_mode
);

    t_mode   r_mode;
    logic    r_in_valid;
    t_sample r_sample;
    logic    r_first;
    t_acc    r_acc;
    t_sample r_prev_odd;
    t_sample r_held_even;
    logic    r_odd_phase;
    logic    r_out_valid;
    t_sample r_out;

    t_acc    n_acc;
    t_sample n_prev_odd;
    t_sample n_held_even;
    logic    n_odd_phase;
    t_sample n_out;

    logic    odd_eff;
    t_acc    acc0;
    t_sample prev_eff;
    t_acc    sum;
    t_acc    a1;
    t_acc    v;
    logic    s2_emit;
    logic    s2_take;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_sample_out = r_out;

    // start flag clears the accumulator, seeds prev and restarts at the even phase
    assign odd_eff  = r_first ? 1'b0 : r_odd_phase;
    assign acc0     = r_first ? '0 : r_acc;
    assign prev_eff = r_first ? r_sample : r_prev_odd;

    assign s2_emit = (r_mode == MODE_REDUCE) || odd_eff;
    assign s2_take = r_in_valid && (!s2_emit || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || s2_take;

    always_comb begin
        n_acc       = acc0;
        n_prev_odd  = prev_eff;
        n_held_even = r_held_even;
        n_odd_phase = odd_eff;
        n_out       = '0;
        sum         = '0;
        a1          = acc0;
        v           = '0;
        if (r_mode == MODE_REDUCE) begin
            a1 = acc0 + RED_BIAS + sext16(r_sample);
            v  = (a1 + RED_ROUND) & RED_MASK;
            if (signed_gt(v, RED_LIMIT)) begin
                v = RED_LIMIT;
            end
            n_acc = a1 - v;
            n_out = {8'd0, v[15:8]};
        end else if (!odd_eff) begin
            n_held_even = r_sample;
            n_odd_phase = 1'b1;
        end else begin
            n_odd_phase = 1'b0;
            n_prev_odd  = r_sample;
            case (r_mode)
                MODE_HALVE8: begin
                    sum = {24'd0, prev_eff[7:0]} + {23'd0, r_held_even[7:0], 1'b0}
                        + {24'd0, r_sample[7:0]};
                    a1 = acc0 + sum;
                    v  = (a1 + QUARTER_ROUND) & H8_MASK;
                    n_out = {8'd0, v[9:2]};
                end
                MODE_HALVE16: begin
                    sum = sext16(prev_eff) + PAIR_BIAS
                        + {{15{r_held_even[15]}}, r_held_even, 1'b0}
                        + sext16(r_sample);
                    a1 = acc0 + sum;
                    v  = (a1 + QUARTER_ROUND) & H16_MASK;
                    n_out = v[17:2] - OUT_OFFSET;
                end
                default: begin
                    sum = sext16(prev_eff) + PAIR_BIAS
                        + {{15{r_held_even[15]}}, r_held_even, 1'b0}
                        + sext16(r_sample);
                    a1 = acc0 + sum;
                    v  = (a1 + HR_ROUND) & HR_MASK;
                    if (signed_gt(v, HR_LIMIT)) begin
                        v = HR_LIMIT;
                    end
                    n_out = {8'd0, v[17:10]};
                end
            endcase
            n_acc = a1 - v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HALVE16;
            r_in_valid  <= 1'b0;
            r_acc       <= '0;
            r_prev_odd  <= '0;
            r_held_even <= '0;
            r_odd_phase <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_mode;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (s2_take) begin
                r_acc       <= n_acc;
                r_prev_odd  <= n_prev_odd;
                r_held_even <= n_held_even;
                r_odd_phase <= n_odd_phase;
            end
            if (s2_take && s2_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_sample_in;
            r_first  <= i_first_of_buffer;
        end
        if (s2_take && s2_emit) begin
            r_out <= n_out;
        end
    end

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_take && s2_emit |=> r_out_valid)
        else $error("emitted word did not reach the output register");

    a_byte_modes_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_mode != MODE_HALVE16 |-> r_out[15:8] == 8'd0)
        else $error("byte mode result has nonzero upper byte");

    a_start_even_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_take && r_first && r_mode != MODE_REDUCE |=> r_odd_phase)
        else $error("start word in halving mode did not begin a pair");

endmodule

// ===== sim/phr_checker.sv =====
// phr_checker: watches the word, result and mode channels of the pcm halve and requantize unit,
// predicts every result word and compares it with what the unit returns
// depends on phr_pkg
`timescale 1ns / 1ps

module phr_checker
    import phr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_sample_in,
    input  logic        i_first_of_buffer,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_sample_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_mode,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // own copy of the unit state
    t_acc    acc;
    t_sample prev_odd;
    t_sample held_even;
    logic    odd_phase;
    t_mode   cur_mode;

    t_sample expected_samples[$];
    t_sample want;
    t_sample res;
    logic    emit;

    task automatic requantize_word(input t_sample s, input logic first,
                                   output logic produced, output t_sample out_word);
        t_acc v;
        t_acc pair_sum;
        produced = 1'b0;
        out_word = '0;
        if (first) begin
            acc       = '0;
            prev_odd  = s;
            odd_phase = 1'b0;
        end
        if (cur_mode == MODE_REDUCE) begin
            acc = acc + RED_BIAS + {{16{s[15]}}, s};
            v = (acc + RED_ROUND) & RED_MASK;
            if (!v[31] && v > RED_LIMIT) begin
                v = RED_LIMIT;
            end
            acc = acc - v;
            out_word = {8'h00, v[15:8]};
            produced = 1'b1;
        end else if (!odd_phase) begin
            held_even = s;
            odd_phase = 1'b1;
        end else begin
            odd_phase = 1'b0;
            if (cur_mode == MODE_HALVE8) begin
                // unsigned bytes, prev_odd keeps all 16 bits but only the low byte counts
                acc = acc + {24'h0, prev_odd[7:0]} + {23'h0, held_even[7:0], 1'b0}
                    + {24'h0, s[7:0]};
                v = (acc + QUARTER_ROUND) & H8_MASK;
                acc = acc - v;
                out_word = {8'h00, v[9:2]};
            end else begin
                pair_sum = {{16{prev_odd[15]}}, prev_odd} + PAIR_BIAS
                         + {{15{held_even[15]}}, held_even, 1'b0} + {{16{s[15]}}, s};
                acc = acc + pair_sum;
                if (cur_mode == MODE_HALVE16) begin
                    v = (acc + QUARTER_ROUND) & H16_MASK;
                    out_word = v[17:2] - OUT_OFFSET;
                end else begin
                    // only the positive side is clamped
                    v = (acc + HR_ROUND) & HR_MASK;
                    if (!v[31] && v > HR_LIMIT) begin
                        v = HR_LIMIT;
                    end
                    out_word = {8'h00, v[17:10]};
                end
                acc = acc - v;
            end
            prev_odd = s;
            produced = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc          = '0;
            prev_odd     = '0;
            held_even    = '0;
            odd_phase    = 1'b0;
            cur_mode     = MODE_HALVE16;
            o_fail_count = 0;
            o_checked    = 0;
            expected_samples.delete();
        end else begin
            // a result word can never come from a word taken at this same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample_out: unexpected word, expected none, actual %h", i_sample_out);
                    o_fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    o_checked++;
                    if (want !== i_sample_out) begin
                        $error("sample_out mismatch: expected %h, actual %h", want, i_sample_out);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cur_mode = i_cfg_mode;
            end
            if (i_in_valid && i_in_ready) begin
                requantize_word(i_sample_in, i_first_of_buffer, emit, res);
                if (emit) begin
                    expected_samples.push_back(res);
                end
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

// ===== sim/pcm_halve_and_requantize_unit_tb.sv =====
// pcm_halve_and_requantize_unit_tb: stimulus, output stalls and verdict for the halve and
// requantize unit, with phr_checker predicting and comparing beside it
// depends on phr_pkg, pcm_halve_and_requantize_unit and phr_checker
`timescale 1ns / 1ps

module pcm_halve_and_requantize_unit_tb;
    import phr_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 6;
    localparam int PHASES           = 10;
    localparam int WORDS_PER_PHASE  = 135;
    localparam int PRESSURE_PHASE   = 4;
    localparam int PRESSURE_WORDS   = 40;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef enum logic [1:0] {
        STY_ANY,
        STY_HIGH,
        STY_LOW,
        STY_QUIET
    } t_sample_style;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic [15:0] i_sample_in       = '0;
    logic        i_first_of_buffer = 1'b0;
    logic        i_ready           = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic [1:0]  i_cfg_mode        = MODE_HALVE16;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_sample_out;
    logic        o_cfg_ready;

    int fail_count;
    int results_pending;
    int results_checked;

    int   cycles        = 0;
    int   words_sent    = 0;
    int   mode_writes   = 0;
    int   hold_requests = 0;
    int   holds_done    = 0;
    logic src_idle_en   = 1'b1;
    logic sink_idle_en  = 1'b1;

    t_mode phase_modes [0:PHASES-1] = '{MODE_HALVE16, MODE_REDUCE, MODE_HALVE8, MODE_HALVE_RED,
                                        MODE_REDUCE, MODE_HALVE16, MODE_HALVE_RED, MODE_HALVE8,
                                        MODE_REDUCE, MODE_HALVE16};

    pcm_halve_and_requantize_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample_in       (i_sample_in),
        .i_first_of_buffer (i_first_of_buffer),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_sample_out      (o_sample_out),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_mode        (i_cfg_mode)
    );

    phr_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_sample_in       (i_sample_in),
        .i_first_of_buffer (i_first_of_buffer),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_sample_out      (o_sample_out),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_mode        (i_cfg_mode),
        .o_fail_count      (fail_count),
        .o_pending         (results_pending),
        .o_checked         (results_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    always begin
        @(posedge i_clk);
        if (holds_done != hold_requests) begin
            i_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            holds_done++;
            i_ready <= 1'b1;
        end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
            i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic t_sample pick_sample(input t_sample_style sty);
        logic [31:0] r;
        r = $urandom;
        case (sty)
            STY_HIGH:  pick_sample = 16'h7FFF - {8'h00, r[7:0]};
            STY_LOW:   pick_sample = 16'h8000 + {8'h00, r[7:0]};
            STY_QUIET: pick_sample = {{10{r[5]}}, r[5:0]};
            default: begin
                if (r[31:28] != 4'h0) begin
                    pick_sample = r[15:0];
                end else if (r[17]) begin
                    pick_sample = r[16] ? 16'h7FFF : 16'h8000;
                end else begin
                    pick_sample = r[16] ? 16'hFFFF : 16'h0000;
                end
            end
        endcase
    endfunction

    // valid stays high from one word to the next unless a gap is taken
    task automatic send_word(input t_sample s, input logic first);
        if (src_idle_en && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_sample_in       <= s;
        i_first_of_buffer <= first;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // an even-phase word leaves nothing pending, so allow the pipeline to settle too
    task automatic wait_until_drained;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        wait_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_mode  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    initial begin : stimulus
        int            block_len;
        int            sent_in_phase;
        t_sample_style sty;
        logic          flag;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, start flag on the odd word, clamps
        write_mode(MODE_HALVE16);
        send_word(16'h7FFF, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h1234, 1'b0);
        // start flag while a word is held drops the trailing one
        send_word(16'h4321, 1'b1);
        send_word(16'h8000, 1'b0);

        write_mode(MODE_HALVE_RED);
        send_word(16'h7FFF, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h8000, 1'b0);

        write_mode(MODE_HALVE8);
        send_word(16'hA5FF, 1'b1);
        send_word(16'h00FF, 1'b0);
        send_word(16'hFF00, 1'b0);
        send_word(16'h5A00, 1'b0);

        write_mode(MODE_REDUCE);
        send_word(16'h7FFF, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h8000, 1'b0);

        // random buffers; a phase may start mid-buffer so a pair can straddle a mode change
        for (int p = 0; p < PHASES; p++) begin
            write_mode(phase_modes[p]);
            sent_in_phase = 0;
            while (sent_in_phase < WORDS_PER_PHASE) begin
                block_len    = $urandom_range(1, 48);
                sty          = t_sample_style'($urandom_range(0, 3));
                src_idle_en  = (p != PHASES - 1) && ($urandom_range(0, 4) != 0);
                sink_idle_en = (p != PHASES - 1) && ($urandom_range(0, 4) != 0);
                for (int k = 0; k < block_len; k++) begin
                    if (k == 0) begin
                        flag = ($urandom_range(0, 7) != 0);
                    end else begin
                        flag = ($urandom_range(0, 63) == 0);
                    end
                    send_word(pick_sample(sty), flag);
                end
                sent_in_phase += block_len;
            end
            if (p == PRESSURE_PHASE) begin
                // hold the result side off while words keep coming, then drain
                src_idle_en = 1'b0;
                hold_requests++;
                for (int k = 0; k < PRESSURE_WORDS; k++) begin
                    send_word(pick_sample(STY_ANY), k == 0);
                end
                wait_until_drained();
            end
        end

        wait_until_drained();
        $display("covered %0d input words, %0d result words checked, %0d mode writes",
                 words_sent, results_checked, mode_writes);
        $display("all four modes, start flags, clamps, long output hold-off and random gaps");
        if (fail_count == 0 && results_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
